### src/lahc_acceptance_unit_core_defines.svh
// Assertion macros for the LAHC acceptance unit.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef LAHC_ACCEPTANCE_UNIT_CORE_DEFINES_SVH
`define LAHC_ACCEPTANCE_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define LAHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define LAHC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define LAHC_ASSERT(lbl, prop, msg)

`define LAHC_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

### src/lahc_pkg.sv
package lahc_pkg;

  localparam int unsigned COST_W    = 48;
  localparam int unsigned HLEN_W    = 7;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_LIMIT = 1'b1;

  // Request kinds (tuser on the input stream)
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_CAND  = 1'b1;

  localparam logic [HLEN_W-1:0]  HIST_LENGTH_RST   = 7'd1;
  localparam logic [LIMIT_W-1:0] RESTART_LIMIT_RST = 16'd1000;

  typedef logic [COST_W-1:0] cost_t;

endpackage

### src/lahc_acceptance_unit_core.sv
// LAHC acceptance unit: late-acceptance judge for an iterated local search.
// Flow: the input transfer registers the item and issues the history RAM read; the commit
//   then registers the result and raises tvalid, and waits while the output is stalled.
//   A new item is taken only after the item in flight has committed (RAM read-modify-write).
// Reset: rst_ni asynchronous, active low; clears control, costs and counters, config to defaults.
//   The history RAM is not cleared; a fill count marks slots not yet written.
`include "lahc_acceptance_unit_core_defines.svh"

module lahc_acceptance_unit_core #(
  parameter int unsigned HIST_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [lahc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lahc_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lahc_pkg::COST_W-1:0]     s_axis_tdata_i,   // [47:0] cost
  input  logic                            s_axis_tuser_i,   // [0] req_type
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [2*lahc_pkg::COST_W-1:0]   m_axis_tdata_o,   // [47:0] best_cost,
                                                            // [95:48] current_cost
  output logic [2:0]                      m_axis_tuser_o    // [0] accepted, [1] new_best,
                                                            // [2] restarted
);

  import lahc_pkg::*;

  localparam int unsigned AW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned LW   = $clog2(HIST_DEPTH + 1);
  localparam int unsigned LENW = (LW > HLEN_W) ? LW : HLEN_W;
  localparam logic [LENW-1:0] DEPTH_L = LENW'(HIST_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [HLEN_W-1:0]  hist_len_q, hist_len_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;

  always_comb begin
    hist_len_d = hist_len_q;
    limit_d    = limit_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HIST_LENGTH:   hist_len_d = cfg_data_i[HLEN_W-1:0];
        REG_RESTART_LIMIT: limit_d    = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring length in use: zero acts as one, saturates at the RAM depth
  logic [LENW-1:0] hl_ext, ring_len;
  assign hl_ext   = LENW'(hist_len_q);
  assign ring_len = (hl_ext == '0)     ? LENW'(1) :
                    (hl_ext > DEPTH_L) ? DEPTH_L  : hl_ext;

  // ---------------------------------------------------------------------------
  // Search state
  // ---------------------------------------------------------------------------
  cost_t             cur_q, cur_d;
  cost_t             best_q, best_d;
  cost_t             init_q, init_d;
  logic [LIMIT_W-1:0] stale_q, stale_d;
  logic [AW-1:0]     slot_index_q, slot_index_d;
  // Slots below fill_q were written since the last clear. The ring starts at 0
  // after a clear and steps by one, and an empty slot is always written when
  // visited, so the written slots are always a prefix of the ring.
  logic [LW-1:0]     fill_q, fill_d;

  // ---------------------------------------------------------------------------
  // Stage 1: accept, issue the history read, pre-compare against state.
  // State only changes on commit and a new item is only taken with the stage
  // empty, so compares done here still hold at commit.
  // ---------------------------------------------------------------------------
  logic          stg_v_q, stg_v_d;
  logic          stg_kind_q;
  cost_t         stg_cost_q;
  logic [AW-1:0] stg_slot_q;
  logic          stg_lt_best_q;
  logic          stg_lt_cur_q;

  logic          in_xfer;
  logic [AW-1:0] rd_slot;

  assign s_axis_tready_o = !stg_v_q;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  // index beyond a shrunk ring falls back to slot 0
  assign rd_slot = (LENW'(slot_index_q) < ring_len) ? slot_index_q : '0;

  // ---------------------------------------------------------------------------
  // History RAM
  // ---------------------------------------------------------------------------
  logic  ram_we;
  cost_t ram_wdata;
  cost_t ram_rdata;

  lahc_ram #(
    .WIDTH (COST_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (stg_slot_q),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (rd_slot),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: commit. Needs the output register free or draining.
  // ---------------------------------------------------------------------------
  logic           out_v_q, out_v_d;
  logic           out_acc_q, out_acc_d;
  logic           out_nb_q, out_nb_d;
  logic           out_rst_q, out_rst_d;
  cost_t          out_best_q, out_best_d;
  cost_t          out_cur_q, out_cur_d;

  logic           commit;
  logic           slot_vacant;
  cost_t          late;
  logic           c_lt_late, cur_lt_late;
  logic           acc;
  cost_t          cur_upd, best_upd;
  logic           hist_wr;
  logic [LIMIT_W-1:0] stale_inc, stale_upd;
  logic           do_restart;
  logic [LENW-1:0] slot_inc;
  logic [AW-1:0]  slot_nxt;
  logic [LW-1:0]  fill_upd;

  assign commit = stg_v_q && (!out_v_q || m_axis_tready_i);

  assign slot_vacant = LENW'(stg_slot_q) >= LENW'(fill_q);
  assign late        = slot_vacant ? init_q : ram_rdata;
  assign c_lt_late   = stg_cost_q < late;
  assign cur_lt_late = cur_q < late;
  assign acc         = c_lt_late || stg_lt_cur_q;
  assign cur_upd     = acc ? stg_cost_q : cur_q;
  // write history if the new current is below the late value (two parallel compares) or the slot is vacant
  assign hist_wr     = (acc ? c_lt_late : cur_lt_late) || slot_vacant;
  assign best_upd    = stg_lt_best_q ? stg_cost_q : best_q;

  assign stale_inc  = (stale_q == '1) ? stale_q : stale_q + LIMIT_W'(1);
  assign stale_upd  = stg_lt_best_q ? '0 : stale_inc;
  assign do_restart = stale_upd >= limit_q;

  assign slot_inc = LENW'(stg_slot_q) + LENW'(1);
  assign slot_nxt = (slot_inc >= ring_len) ? '0 : slot_inc[AW-1:0];
  assign fill_upd = slot_vacant ? fill_q + LW'(1) : fill_q;

  assign ram_we    = commit && (stg_kind_q == REQ_CAND) && hist_wr;
  assign ram_wdata = cur_upd;

  always_comb begin
    stg_v_d      = stg_v_q;
    cur_d        = cur_q;
    best_d       = best_q;
    init_d       = init_q;
    stale_d      = stale_q;
    slot_index_d = slot_index_q;
    fill_d       = fill_q;
    out_v_d      = out_v_q;
    out_acc_d    = out_acc_q;
    out_nb_d     = out_nb_q;
    out_rst_d    = out_rst_q;
    out_best_d   = out_best_q;
    out_cur_d    = out_cur_q;

    if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
    if (in_xfer) begin
      stg_v_d = 1'b1;
    end

    if (commit) begin
      stg_v_d = 1'b0;
      out_v_d = 1'b1;
      if (stg_kind_q == REQ_START) begin
        init_d       = stg_cost_q;
        cur_d        = stg_cost_q;
        best_d       = stg_cost_q;
        stale_d      = '0;
        slot_index_d = '0;
        fill_d       = '0;
        out_acc_d    = 1'b0;
        out_nb_d     = 1'b0;
        out_rst_d    = 1'b0;
        out_best_d   = stg_cost_q;
        out_cur_d    = stg_cost_q;
      end else begin
        best_d    = best_upd;
        out_acc_d = acc;
        out_nb_d  = stg_lt_best_q;
        out_best_d = best_upd;
        if (do_restart) begin
          // fall back to best, history starts over
          cur_d        = best_upd;
          stale_d      = '0;
          slot_index_d = '0;
          fill_d       = '0;
          out_rst_d    = 1'b1;
          out_cur_d    = best_upd;
        end else begin
          cur_d        = cur_upd;
          stale_d      = stale_upd;
          slot_index_d = slot_nxt;
          fill_d       = fill_upd;
          out_rst_d    = 1'b0;
          out_cur_d    = cur_upd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_len_q   <= HIST_LENGTH_RST;
      limit_q      <= RESTART_LIMIT_RST;
      cur_q        <= '0;
      best_q       <= '0;
      init_q       <= '0;
      stale_q      <= '0;
      slot_index_q <= '0;
      fill_q       <= '0;
      stg_v_q      <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      hist_len_q   <= hist_len_d;
      limit_q      <= limit_d;
      cur_q        <= cur_d;
      best_q       <= best_d;
      init_q       <= init_d;
      stale_q      <= stale_d;
      slot_index_q <= slot_index_d;
      fill_q       <= fill_d;
      stg_v_q      <= stg_v_d;
      out_v_q      <= out_v_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stg_kind_q    <= s_axis_tuser_i;
      stg_cost_q    <= s_axis_tdata_i;
      stg_slot_q    <= rd_slot;
      stg_lt_best_q <= s_axis_tdata_i < best_q;
      stg_lt_cur_q  <= s_axis_tdata_i < cur_q;
    end
    out_acc_q  <= out_acc_d;
    out_nb_q   <= out_nb_d;
    out_rst_q  <= out_rst_d;
    out_best_q <= out_best_d;
    out_cur_q  <= out_cur_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_cur_q, out_best_q};
  assign m_axis_tuser_o  = {out_rst_q, out_nb_q, out_acc_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // ring index never runs ahead of the written prefix
  `LAHC_ASSERT(a_index_in_fill, LW'(slot_index_q) <= fill_q, "slot index beyond fill count")
  // best is never worse than current
  `LAHC_ASSERT(a_best_le_cur, best_q <= cur_q, "best cost above current cost")
  // a restart result reports current equal to best
  `LAHC_ASSERT_IMPL(a_restart_cur, out_v_q && out_rst_q, out_cur_q == out_best_q, "bad restart")
  // a new result only appears from a committing stage
  `LAHC_ASSERT_IMPL(a_out_from_stage, $rose(out_v_q), $past(stg_v_q), "result without item")

endmodule

### src/lahc_ram.sv
module lahc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
